[rtl/rfv_pkg.sv]
// shared types and constants for the refraction pipeline
package rfv_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 20;

  localparam logic signed [63:0] OUT_MAX = 64'sd524287;
  localparam logic signed [63:0] OUT_MIN = -64'sd524288;
  localparam logic signed [63:0] T_LIMIT = 64'sd1 <<< 37;

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } vec_t;

  // operands that ride along with an item until the final combine
  typedef struct packed {
    logic [IN_W-1:0] eta;
    vec_t            inc;
    vec_t            nrm;
  } ctx_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    tir;
  } result_t;

endpackage

[rtl/rfv_isqrt.sv]
// pipelined digit-by-digit integer square root, two root bits per stage
module rfv_isqrt #(
  parameter int RAD_W = 44,
  parameter int TAG_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [TAG_W-1:0]     tag_i,
  output logic                 valid_o,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [TAG_W-1:0]     tag_o
);

  localparam int NSTG  = RAD_W / 4;
  localparam int QE    = RAD_W / 2;
  localparam int REM_W = QE + 2;

  logic             vld_q  [NSTG];
  logic [REM_W-1:0] rem_q  [NSTG];
  logic [QE-1:0]    root_q [NSTG];
  logic [RAD_W-1:0] rad_q  [NSTG];
  logic [TAG_W-1:0] tag_q  [NSTG];

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic             vld_in;
    logic [REM_W-1:0] rem_in;
    logic [QE-1:0]    root_in;
    logic [RAD_W-1:0] rad_in;
    logic [TAG_W-1:0] tag_in;
    logic [REM_W-1:0] rem_nx;
    logic [QE-1:0]    root_nx;
    logic [RAD_W-1:0] rad_nx;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign tag_in  = tag_q[s-1];
    end

    always_comb begin
      logic [REM_W-1:0] sh;
      logic [REM_W-1:0] trial;
      rem_nx  = rem_in;
      root_nx = root_in;
      rad_nx  = rad_in;
      sh      = '0;
      trial   = '0;
      for (int j = 0; j < 2; j++) begin
        sh    = {rem_nx[QE-1:0], rad_nx[RAD_W-1 -: 2]};
        trial = {root_nx, 2'b01};
        if (sh >= trial) begin
          rem_nx  = sh - trial;
          root_nx = {root_nx[QE-2:0], 1'b1};
        end else begin
          rem_nx  = sh;
          root_nx = {root_nx[QE-2:0], 1'b0};
        end
        rad_nx = rad_nx << 2;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_nx;
      root_q[s] <= root_nx;
      rad_q[s]  <= rad_nx;
      tag_q[s]  <= tag_in;
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign root_o  = root_q[NSTG-1];
  assign tag_o   = tag_q[NSTG-1];

endmodule

[rtl/refract_vector.sv]
// refraction of a direction at a surface, fully pipelined fixed point
//
//  channel  | valid       | stall        | payload
//  ---------+-------------+--------------+--------------------------------------------
//  input    | in_valid_i  | in_stall_o   | incident_x/y/z_i, normal_x/y/z_i, index_ratio_i
//  output   | out_valid_o | out_stall_i  | refracted_x/y/z_o, total_reflection_o
//
// one item enters per cycle while in_stall_o is low; the pipeline is 9 + ceil(RW/4) register
// stages deep, RW being the root radicand width (11 root stages, 20 stages for FRAC_BITS=14)
// the square root unit (two root bits per stage) sets the depth, the multipliers the stage cut
// the pipeline never stalls; finished items land in an output queue with room for everything
// in flight, and in_stall_o rises only when queue and pipeline together are full
// reset clears all valid bits, queue pointers and the in-flight count; data registers keep
// whatever they hold
module refract_vector #(
  parameter int FRAC_BITS = rfv_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [rfv_pkg::IN_W-1:0]   incident_x_i,
  input  logic signed [rfv_pkg::IN_W-1:0]   incident_y_i,
  input  logic signed [rfv_pkg::IN_W-1:0]   incident_z_i,
  input  logic signed [rfv_pkg::IN_W-1:0]   normal_x_i,
  input  logic signed [rfv_pkg::IN_W-1:0]   normal_y_i,
  input  logic signed [rfv_pkg::IN_W-1:0]   normal_z_i,
  input  logic        [rfv_pkg::IN_W-1:0]   index_ratio_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rfv_pkg::OUT_W-1:0]  refracted_x_o,
  output logic signed [rfv_pkg::OUT_W-1:0]  refracted_y_o,
  output logic signed [rfv_pkg::OUT_W-1:0]  refracted_z_o,
  output logic                              total_reflection_o
);

  localparam int F    = FRAC_BITS;
  localparam int DW   = 34 - F;                                  // d = N.I
  localparam int EW   = 33 - F;                                  // eta squared
  localparam int XW   = ((2 * DW > 2 * F + 2) ? 2 * DW : 2 * F + 2) + 1;
  localparam int TRW  = XW - F;                                  // 1 - d^2 before clamp
  localparam int TNEG = (65 - 3 * F < 38) ? 65 - 3 * F : 38;
  localparam int TW   = (F + 2 > TNEG) ? F + 2 : TNEG;           // clamped 1 - d^2
  localparam int TL   = TW / 2;
  localparam int TH   = TW - TL;
  localparam int PW   = EW + TW + 1;                             // eta^2 * (1 - d^2)
  localparam int RPW  = PW - F;
  localparam int KW   = ((RPW > F + 2) ? RPW : F + 2) + 1;       // k, signed
  localparam int RW   = KW - 1 + F;                              // radicand k << F
  localparam int NSTG = (RW + 3) / 4;
  localparam int RWE  = 4 * NSTG;
  localparam int QE   = 2 * NSTG;
  localparam int EDW  = DW + 17;                                 // eta * d
  localparam int RDW  = EDW - F;
  localparam int AW   = ((RDW > QE + 1) ? RDW : QE + 1) + 1;     // eta*d + sqrt(k)
  localparam int MW   = AW + 16;                                 // a * N_j
  localparam int DFW  = ((MW > 33) ? MW : 33) + 2;
  localparam int DEPTH = NSTG + 12;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [63:0] HALF  = 64'd1 << (F - 1);
  localparam logic [63:0] ONE_F = 64'd1 << F;
  localparam logic [63:0] ONE_2F = 64'd1 << (2 * F);
  localparam logic signed [63:0] NEG_T_LIMIT = -rfv_pkg::T_LIMIT;

  typedef struct packed {
    rfv_pkg::ctx_t         ctx;
    logic signed [RDW-1:0] red;
    logic                  neg;
  } tag_t;

  // handshake and in-flight accounting
  logic in_acc;
  logic out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, va_q, vb_q;
  logic sq_valid;

  // stage 1: dot product terms and eta squared
  rfv_pkg::ctx_t      ctx1_q;
  logic signed [31:0] prod1_q [3];
  logic [31:0]        esq1_q;

  // stage 2: rounded d and eta^2
  rfv_pkg::ctx_t        ctx2_q;
  logic signed [DW-1:0] d2_q;
  logic [EW-1:0]        e2_2_q;
  logic [33:0]          sum2;
  logic [32:0]          esq2;

  // stage 3: d*d and eta*d
  rfv_pkg::ctx_t           ctx3_q;
  logic signed [2*DW-1:0]  dd3_q;
  logic signed [EDW-1:0]   ed3_q;
  logic [EW-1:0]           e2_3_q;

  // stage 4: clamped 1 - d^2 and rounded eta*d
  rfv_pkg::ctx_t         ctx4_q;
  logic signed [TW-1:0]  t4_q;
  logic signed [RDW-1:0] red4_q;
  logic [EW-1:0]         e2_4_q;
  logic [XW-1:0]         x4;
  logic [EDW-1:0]        edr4;
  logic signed [63:0]    text4;
  logic signed [63:0]    tcl4;

  // stage 5: eta^2 times the two halves of t
  rfv_pkg::ctx_t               ctx5_q;
  logic signed [RDW-1:0]       red5_q;
  logic [EW+TL-1:0]            plo5_q;
  logic signed [EW+TH:0]       phi5_q;

  // stage 6: full product
  rfv_pkg::ctx_t         ctx6_q;
  logic signed [RDW-1:0] red6_q;
  logic signed [PW-1:0]  p6_q;

  // stage 7: k
  rfv_pkg::ctx_t         ctx7_q;
  logic signed [RDW-1:0] red7_q;
  logic [KW-1:0]         k7_q;
  logic [PW-1:0]         pr7;
  logic [KW-1:0]         k7_d;

  // square root
  tag_t            sq_tag_in;
  tag_t            sq_tag;
  logic [RWE-1:0]  sq_rad;
  logic [QE-1:0]   sq_root;

  // stage a: a = eta*d + sqrt(k), eta*I
  logic signed [AW-1:0]  a_q;
  logic signed [32:0]    ei_a_q [3];
  rfv_pkg::vec_t         nrm_a_q;
  logic                  neg_a_q;

  // stage b: a*N
  logic signed [32:0]    ei_b_q [3];
  logic signed [MW-1:0]  an_b_q [3];
  logic                  neg_b_q;

  // output queue
  rfv_pkg::result_t res_c;
  rfv_pkg::result_t fifo_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fcnt_q, occ_q;

  function automatic logic signed [rfv_pkg::OUT_W-1:0] finish(
    input logic signed [32:0]   ei,
    input logic signed [MW-1:0] an
  );
    logic [DFW-1:0]     diff;
    logic signed [63:0] r;
    diff = DFW'(ei) - DFW'(an) + DFW'(HALF);
    r    = 64'($signed(diff[DFW-1:F]));
    if (r > rfv_pkg::OUT_MAX) begin
      r = rfv_pkg::OUT_MAX;
    end else if (r < rfv_pkg::OUT_MIN) begin
      r = rfv_pkg::OUT_MIN;
    end
    return rfv_pkg::OUT_W'(r);
  endfunction

  // rounding and clamping between stages
  always_comb begin
    sum2  = 34'(prod1_q[0]) + 34'(prod1_q[1]) + 34'(prod1_q[2]) + 34'(HALF);
    esq2  = 33'(esq1_q) + 33'(HALF);
    x4    = XW'(ONE_2F) - XW'(dd3_q) + XW'(HALF);
    edr4  = EDW'(ed3_q) + EDW'(HALF);
    text4 = 64'($signed(x4[XW-1:F]));
    tcl4  = text4;
    if (text4 > rfv_pkg::T_LIMIT) begin
      tcl4 = rfv_pkg::T_LIMIT;
    end else if (text4 < NEG_T_LIMIT) begin
      tcl4 = NEG_T_LIMIT;
    end
    pr7  = PW'(p6_q) + PW'(HALF);
    k7_d = KW'(ONE_F) - KW'($signed(pr7[PW-1:F]));
  end

  // a negative k is total internal reflection; its root is never used
  assign sq_rad        = k7_q[KW-1] ? '0 : RWE'({k7_q[KW-2:0], {F{1'b0}}});
  assign sq_tag_in.ctx = ctx7_q;
  assign sq_tag_in.red = red7_q;
  assign sq_tag_in.neg = k7_q[KW-1];

  rfv_isqrt #(
    .RAD_W (RWE),
    .TAG_W ($bits(tag_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .rad_i   (sq_rad),
    .tag_i   (sq_tag_in),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  always_comb begin
    res_c.x   = finish(ei_b_q[0], an_b_q[0]);
    res_c.y   = finish(ei_b_q[1], an_b_q[1]);
    res_c.z   = finish(ei_b_q[2], an_b_q[2]);
    res_c.tir = neg_b_q;
    if (neg_b_q) begin
      res_c.x = '0;
      res_c.y = '0;
      res_c.z = '0;
    end
  end

  // data path registers, no reset
  always_ff @(posedge clk_i) begin
    ctx1_q.eta   <= index_ratio_i;
    ctx1_q.inc.x <= incident_x_i;
    ctx1_q.inc.y <= incident_y_i;
    ctx1_q.inc.z <= incident_z_i;
    ctx1_q.nrm.x <= normal_x_i;
    ctx1_q.nrm.y <= normal_y_i;
    ctx1_q.nrm.z <= normal_z_i;
    prod1_q[0]   <= incident_x_i * normal_x_i;
    prod1_q[1]   <= incident_y_i * normal_y_i;
    prod1_q[2]   <= incident_z_i * normal_z_i;
    esq1_q       <= index_ratio_i * index_ratio_i;

    ctx2_q <= ctx1_q;
    d2_q   <= $signed(sum2[33:F]);
    e2_2_q <= esq2[32:F];

    ctx3_q <= ctx2_q;
    dd3_q  <= d2_q * d2_q;
    ed3_q  <= $signed({1'b0, ctx2_q.eta}) * d2_q;
    e2_3_q <= e2_2_q;

    ctx4_q <= ctx3_q;
    t4_q   <= tcl4[TW-1:0];
    red4_q <= $signed(edr4[EDW-1:F]);
    e2_4_q <= e2_3_q;

    ctx5_q <= ctx4_q;
    red5_q <= red4_q;
    plo5_q <= e2_4_q * t4_q[TL-1:0];
    phi5_q <= $signed({1'b0, e2_4_q}) * $signed(t4_q[TW-1:TL]);

    ctx6_q <= ctx5_q;
    red6_q <= red5_q;
    p6_q   <= ($signed(PW'(phi5_q)) <<< TL) + $signed(PW'(plo5_q));

    ctx7_q <= ctx6_q;
    red7_q <= red6_q;
    k7_q   <= k7_d;

    a_q       <= AW'(sq_tag.red) + $signed(AW'(sq_root));
    ei_a_q[0] <= $signed({1'b0, sq_tag.ctx.eta}) * sq_tag.ctx.inc.x;
    ei_a_q[1] <= $signed({1'b0, sq_tag.ctx.eta}) * sq_tag.ctx.inc.y;
    ei_a_q[2] <= $signed({1'b0, sq_tag.ctx.eta}) * sq_tag.ctx.inc.z;
    nrm_a_q   <= sq_tag.ctx.nrm;
    neg_a_q   <= sq_tag.neg;

    ei_b_q    <= ei_a_q;
    an_b_q[0] <= a_q * nrm_a_q.x;
    an_b_q[1] <= a_q * nrm_a_q.y;
    an_b_q[2] <= a_q * nrm_a_q.z;
    neg_b_q   <= neg_a_q;

    if (vb_q) begin
      fifo_q[wr_ptr_q] <= res_c;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
      v5_q     <= 1'b0;
      v6_q     <= 1'b0;
      v7_q     <= 1'b0;
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fcnt_q   <= '0;
      occ_q    <= '0;
    end else begin
      v1_q <= in_acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      va_q <= sq_valid;
      vb_q <= va_q;
      if (vb_q) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (out_acc) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      fcnt_q <= fcnt_q + CNT_W'(vb_q) - CNT_W'(out_acc);
      occ_q  <= occ_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // room is reserved for every item in flight, so the queue never overflows
  assign in_stall_o         = (occ_q == CNT_W'(DEPTH));
  assign out_valid_o        = (fcnt_q != '0);
  assign refracted_x_o      = fifo_q[rd_ptr_q].x;
  assign refracted_y_o      = fifo_q[rd_ptr_q].y;
  assign refracted_z_o      = fifo_q[rd_ptr_q].z;
  assign total_reflection_o = fifo_q[rd_ptr_q].tir;

endmodule

[rtl/rfv_checker.sv]
// port-level checks for the refraction pipeline, bound to the top level
module rfv_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [rfv_pkg::OUT_W-1:0]  refracted_x_o,
  input logic signed [rfv_pkg::OUT_W-1:0]  refracted_y_o,
  input logic signed [rfv_pkg::OUT_W-1:0]  refracted_z_o,
  input logic                              total_reflection_o
);

  logic [7:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // items taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pend_q != 8'd0))
    else $error("result shown with no item pending");

  a_tir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && total_reflection_o) |->
      (refracted_x_o == '0 && refracted_y_o == '0 && refracted_z_o == '0))
    else $error("total reflection with nonzero vector");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(refracted_x_o) && $stable(refracted_y_o) &&
       $stable(refracted_z_o) && $stable(total_reflection_o)))
    else $error("stalled result changed");

endmodule

bind refract_vector rfv_checker u_rfv_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .refracted_x_o      (refracted_x_o),
  .refracted_y_o      (refracted_y_o),
  .refracted_z_o      (refracted_z_o),
  .total_reflection_o (total_reflection_o)
);

[test/refract_vector_test.sv]
// self-checking testbench for the refract_vector pipeline
module refract_vector_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC          = rfv_pkg::FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS  = 730;
  // the receiver freezes once this many items went in, long enough to fill
  // the pipeline and its output queue so that in_stall_o has to rise
  localparam int HOLD_AT       = 350;
  localparam int HOLD_CYCLES   = 200;
  // pipeline is about 20 stages deep; give stray results time to show up
  localparam int TAIL_CYCLES   = 64;

  // one incoming ray: incident direction, surface normal, index ratio
  typedef struct packed {
    rfv_pkg::vec_t            inc;
    rfv_pkg::vec_t            nrm;
    logic [rfv_pkg::IN_W-1:0] eta;
  } ray_t;

  // expected refractions in arrival order, with the fixed-point predictor
  class refraction_tracker;
    rfv_pkg::result_t pending_results[$];
    int unsigned      errors;
    int unsigned      accepted;

    // divide by 2^FRAC, round to nearest with ties toward plus infinity
    static function longint round_q(longint x);
      return (x + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    // integer square root, one result bit per pass
    static function longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= res + probe) begin
          v -= res + probe;
          res = (res >> 1) + probe;
        end else begin
          res >>= 1;
        end
        probe >>= 2;
      end
      return res;
    endfunction

    function rfv_pkg::result_t refract_fixed(ray_t r);
      longint                           inc[3];
      longint                           nrm[3];
      longint                           eta, d, t, e2, k, a, v;
      longint unsigned                  s;
      logic signed [rfv_pkg::OUT_W-1:0] comp[3];
      rfv_pkg::result_t                 res;
      int                               j;
      inc[0] = $signed(r.inc.x);
      inc[1] = $signed(r.inc.y);
      inc[2] = $signed(r.inc.z);
      nrm[0] = $signed(r.nrm.x);
      nrm[1] = $signed(r.nrm.y);
      nrm[2] = $signed(r.nrm.z);
      eta = longint'(r.eta);
      // cosine term and 1 - d^2, the latter clamped before the eta^2 product
      d = round_q(inc[0] * nrm[0] + inc[1] * nrm[1] + inc[2] * nrm[2]);
      t = round_q((longint'(1) <<< (2 * FRAC)) - d * d);
      if (t > rfv_pkg::T_LIMIT) t = rfv_pkg::T_LIMIT;
      if (t < -rfv_pkg::T_LIMIT) t = -rfv_pkg::T_LIMIT;
      e2 = round_q(eta * eta);
      k = (longint'(1) <<< FRAC) - round_q(e2 * t);
      res = '0;
      // total internal reflection: zero vector, flag up
      if (k < 0) begin
        res.tir = 1'b1;
        return res;
      end
      s = root_floor(longint'(k) << FRAC);
      a = round_q(eta * d) + longint'(s);
      for (j = 0; j < 3; j++) begin
        v = round_q(eta * inc[j] - a * nrm[j]);
        if (v > rfv_pkg::OUT_MAX) v = rfv_pkg::OUT_MAX;
        if (v < rfv_pkg::OUT_MIN) v = rfv_pkg::OUT_MIN;
        comp[j] = v[rfv_pkg::OUT_W-1:0];
      end
      res.x = comp[0];
      res.y = comp[1];
      res.z = comp[2];
      return res;
    endfunction

    function void note_ray(ray_t r);
      pending_results.push_back(refract_fixed(r));
      accepted++;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void compare_field(string name, logic signed [rfv_pkg::OUT_W-1:0] want,
                                logic signed [rfv_pkg::OUT_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_refraction(rfv_pkg::result_t got);
      rfv_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $error("result arrived with no item outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("refracted_x", want.x, got.x);
      compare_field("refracted_y", want.y, got.y);
      compare_field("refracted_z", want.z, got.z);
      compare_field("total_reflection", rfv_pkg::OUT_W'(want.tir),
                    rfv_pkg::OUT_W'(got.tir));
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic signed [rfv_pkg::IN_W-1:0]   incident_x_i;
  logic signed [rfv_pkg::IN_W-1:0]   incident_y_i;
  logic signed [rfv_pkg::IN_W-1:0]   incident_z_i;
  logic signed [rfv_pkg::IN_W-1:0]   normal_x_i;
  logic signed [rfv_pkg::IN_W-1:0]   normal_y_i;
  logic signed [rfv_pkg::IN_W-1:0]   normal_z_i;
  logic        [rfv_pkg::IN_W-1:0]   index_ratio_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [rfv_pkg::OUT_W-1:0]  refracted_x_o;
  logic signed [rfv_pkg::OUT_W-1:0]  refracted_y_o;
  logic signed [rfv_pkg::OUT_W-1:0]  refracted_z_o;
  logic                              total_reflection_o;

  refraction_tracker tracker;

  // handshake between the two sides: the sender stops idling while the
  // receiver holds off, so the block is sure to fill up
  bit hold_done = 1'b0;
  bit holding   = 1'b0;

  // sender idling alternates between gappy and gap-free stretches
  bit sender_calm      = 1'b0;
  int sender_calm_left = 0;

  refract_vector #(
    .FRAC_BITS(FRAC)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .incident_x_i      (incident_x_i),
    .incident_y_i      (incident_y_i),
    .incident_z_i      (incident_z_i),
    .normal_x_i        (normal_x_i),
    .normal_y_i        (normal_y_i),
    .normal_z_i        (normal_z_i),
    .index_ratio_i     (index_ratio_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .refracted_x_o     (refracted_x_o),
    .refracted_y_o     (refracted_y_o),
    .refracted_z_o     (refracted_z_o),
    .total_reflection_o(total_reflection_o)
  );

  always #6 clk_i = ~clk_i;

  // idle length: mostly none or a few cycles, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // roughly uniform direction of unit length in Q2.14
  function automatic rfv_pkg::vec_t unit_dir();
    real           c[3];
    real           len;
    rfv_pkg::vec_t v;
    int            j;
    do begin
      for (j = 0; j < 3; j++)
        c[j] = real'(int'($urandom_range(0, 20000)) - 10000) / 10000.0;
      len = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
    end while (len < 0.05 || len > 1.0);
    v.x = 16'($rtoi(c[0] / len * 16384.0));
    v.y = 16'($rtoi(c[1] / len * 16384.0));
    v.z = 16'($rtoi(c[2] / len * 16384.0));
    return v;
  endfunction

  // mostly physical rays (unit vectors, eta 0.5 to 2.0) with random content, some unit vectors
  // with a raw eta, the rest raw bit patterns over the whole field ranges
  function automatic ray_t random_ray();
    ray_t r;
    int   pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      r.inc.x = 16'($urandom);
      r.inc.y = 16'($urandom);
      r.inc.z = 16'($urandom);
      r.nrm.x = 16'($urandom);
      r.nrm.y = 16'($urandom);
      r.nrm.z = 16'($urandom);
      r.eta   = 16'($urandom);
    end else begin
      r.inc = unit_dir();
      r.nrm = unit_dir();
      r.eta = (pick < 9) ? 16'($urandom_range(8192, 32768)) : 16'($urandom);
    end
    return r;
  endfunction

  // optional idle gap, then offer the item until the block takes it
  task automatic send_ray(input ray_t r);
    int gap;
    if (sender_calm_left == 0) begin
      sender_calm_left = $urandom_range(10, 60);
      sender_calm = ($urandom_range(0, 3) == 0);
    end
    sender_calm_left--;
    gap = (holding || sender_calm) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    incident_x_i  <= r.inc.x;
    incident_y_i  <= r.inc.y;
    incident_z_i  <= r.inc.z;
    normal_x_i    <= r.nrm.x;
    normal_y_i    <= r.nrm.y;
    normal_z_i    <= r.nrm.z;
    index_ratio_i <= r.eta;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.note_ray(r);
  endtask

  task automatic directed_ray(input int ix, input int iy, input int iz,
                              input int nx, input int ny, input int nz,
                              input int e);
    ray_t r;
    r.inc.x = 16'(ix);
    r.inc.y = 16'(iy);
    r.inc.z = 16'(iz);
    r.nrm.x = 16'(nx);
    r.nrm.y = 16'(ny);
    r.nrm.z = 16'(nz);
    r.eta   = 16'(e);
    send_ray(r);
  endtask

  // stop offering until every outstanding item has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  // results are sampled at the edge, before anything clocked there settles
  always @(posedge clk_i) begin : result_watch
    rfv_pkg::result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.x   = refracted_x_o;
      got.y   = refracted_y_o;
      got.z   = refracted_z_o;
      got.tir = total_reflection_o;
      tracker.check_refraction(got);
    end
  end

  // receiver: short stall bursts, calm stretches, and one long freeze
  initial begin : result_sink
    int run;
    int gap;
    bit calm;
    out_stall_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (!hold_done && tracker.accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        holding = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holding = 1'b0;
      end
      calm = ($urandom_range(0, 4) == 0);
      run = calm ? $urandom_range(20, 80) : $urandom_range(1, 12);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin : ray_source
    int i;
    tracker = new();
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    incident_x_i  <= '0;
    incident_y_i  <= '0;
    incident_z_i  <= '0;
    normal_x_i    <= '0;
    normal_y_i    <= '0;
    normal_z_i    <= '0;
    index_ratio_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all zero: d = 0, k = 1, a = 1, zero output
    directed_ray(0, 0, 0, 0, 0, 0, 0);
    // head-on through a matched surface passes straight through
    directed_ray(0, 0, -16384, 0, 0, 16384, 16384);
    // eta of zero leaves only the normal term
    directed_ray(0, 0, -16384, 0, 0, 16384, 0);
    // grazing ray with eta exactly 1 gives k exactly zero, not a reflection
    directed_ray(16384, 0, 0, 0, 16384, 0, 16384);
    // same ray with eta one lsb above 1 tips k negative
    directed_ray(16384, 0, 0, 0, 16384, 0, 16385);
    // grazing at eta 2.0 reflects totally
    directed_ray(16384, 0, 0, 0, 16384, 0, 32768);
    // head-on at the largest eta: 1 - d^2 is zero
    directed_ray(0, 0, -16384, 0, 0, 16384, 65535);
    // field extremes, non-unit vectors; outputs saturate high and low
    directed_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535);
    directed_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535);
    directed_ray(32767, 32767, 32767, -32768, -32768, -32768, 1);
    directed_ray(-32768, -32768, -32768, 32767, 32767, 32767, 0);
    directed_ray(32767, 32767, 32767, -32768, -32768, -32768, 65535);
    directed_ray(32767, -32768, 32767, -32768, 32767, -32768, 32768);
    // tiny non-unit vectors
    directed_ray(1, -1, 1, -1, 1, -1, 1);
    directed_ray(0, -16384, 0, 0, 16384, 0, 1);
    // 45 degrees into a denser medium, then out of it beyond the critical angle
    directed_ray(11585, 0, -11585, 0, 0, 16384, 12288);
    directed_ray(11585, 0, -11585, 0, 0, 16384, 24576);
    // zero normal: d = 0, k = 0 at eta 1, output equals eta * I
    directed_ray(32767, -32768, 0, 0, 0, 0, 16384);
    directed_ray(-32768, 32767, -1, 0, 0, 0, 65535);
    // sender pause: everything must drain before the random part
    wait_drained();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == (RANDOM_ITEMS * 2) / 3) wait_drained();
      send_ray(random_ray());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("refract_vector_test passed");
    end else begin
      $display("refract_vector_test failed");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin : run_limit
    #10ms;
    $display("refract_vector_test failed");
    $finish;
  end

endmodule

[files.f]
rtl/rfv_pkg.sv
rtl/rfv_isqrt.sv
rtl/refract_vector.sv
rtl/rfv_checker.sv
test/refract_vector_test.sv
